// File: rtl/npf_pkg.sv
// npf_pkg: shared types and fixed widths of the next prime finder
// used by npf_divider and next_prime_finder; no dependencies
package npf_pkg;

   // candidate and result width, input width
   localparam int unsigned CAND_W = 31;
   localparam int unsigned IN_W   = 32;

   // remainder unit retires one dividend bit per cycle
   localparam int unsigned CNT_W    = 5;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAND_W - 1);

   // largest 31-bit value, which bounds the search
   localparam logic [CAND_W-1:0] CAND_TOP    = {CAND_W{1'b1}};
   localparam logic [CAND_W-1:0] SMALL_PRIME = CAND_W'(2);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CAND  = 5'b00010,
      ST_TEST  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_FOUND = 5'b10000
   } state_type;

endpackage

// File: rtl/npf_divider.sv
// npf_divider: restoring remainder unit, one dividend bit per cycle
// depends on npf_pkg for the dividend width and step count
module npf_divider #(
   parameter int unsigned DW = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [npf_pkg::CAND_W-1:0]    dividend,
   input  logic [DW-1:0]                 divisor,
   output logic                          done,
   output logic [DW-1:0]                 remainder
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [npf_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [npf_pkg::CAND_W-1:0]   shift_ff, shift_in;
   logic [DW-1:0]                rem_ff, rem_in;
   logic [DW:0]                  trial;
   logic [DW:0]                  divisor_x;
   logic [DW:0]                  diff;

   // divisor is held steady by the sequencer for the whole pass
   always_comb begin
      trial     = {rem_ff, shift_ff[npf_pkg::CAND_W-1]};
      divisor_x = {1'b0, divisor};
      diff      = trial - divisor_x;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[npf_pkg::CAND_W-2:0], 1'b0};
         if (trial >= divisor_x) begin
            rem_in = diff[DW-1:0];
         end else begin
            rem_in = trial[DW-1:0];
         end
         cnt_in = cnt_ff + npf_pkg::CNT_W'(1);
         if (cnt_ff == npf_pkg::CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/next_prime_finder.sv
// next_prime_finder: top level, sequencer around a shared remainder unit
// depends on npf_pkg and npf_divider
//
// Returns the smallest prime not below a signed 32-bit start value; any start
// of 2 or less gives 2. Candidates are tested upward by trial division with
// divisors 2, 3, 4, ... while the divisor squared is at most the candidate and
// the divisor is at most MAX_TRIAL_DIVISOR. One item is worked at a time and
// req_ready is low meanwhile. Each divisor costs a start in ST_TEST and one
// pass of the bit-serial remainder unit, waited out in ST_DIV; a large prime
// near 2^31 needs some 46000 divisors, and most composites fail within a few
// divisors. A finished result waits in the output register, and the next item
// may be taken while it waits.
module next_prime_finder #(
   parameter int unsigned MAX_TRIAL_DIVISOR = 46340
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [npf_pkg::IN_W-1:0] req_start_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [npf_pkg::CAND_W-1:0]    rsp_next_prime
);

   // divisor must hold one past the bound
   localparam int unsigned DW    = $clog2(MAX_TRIAL_DIVISOR + 2);
   localparam int unsigned SW    = 2 * DW;
   localparam int unsigned CMP_W = (SW > npf_pkg::CAND_W) ? SW : npf_pkg::CAND_W;
   localparam logic [DW-1:0] D_MAX   = DW'(MAX_TRIAL_DIVISOR);
   localparam logic [DW-1:0] D_FIRST = DW'(2);
   localparam logic [SW-1:0] SQ_FIRST = SW'(4);

   npf_pkg::state_type            state_ff, state_in;
   logic [npf_pkg::CAND_W-1:0]    cand_ff, cand_in;
   logic [DW-1:0]                 d_ff, d_in;
   logic [SW-1:0]                 sq_ff, sq_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [npf_pkg::CAND_W-1:0]    rsp_prime_ff, rsp_prime_in;
   logic                          div_start;
   logic                          div_done;
   logic [DW-1:0]                 div_rem;
   logic                          accept;
   logic                          small_start;
   logic [CMP_W-1:0]              sq_cmp;
   logic [CMP_W-1:0]              cand_cmp;
   logic [SW-1:0]                 sq_step;

   npf_divider #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cand_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_ready = (state_ff == npf_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign small_start = req_start_value[npf_pkg::IN_W-1] ||
                        (req_start_value[npf_pkg::CAND_W-1:0] <= npf_pkg::SMALL_PRIME);

   always_comb begin
      sq_cmp   = CMP_W'(sq_ff);
      cand_cmp = CMP_W'(cand_ff);
      // (d+1)^2 = d^2 + 2d + 1
      sq_step  = SW'({d_ff, 1'b1});
      state_in     = state_ff;
      cand_in      = cand_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         npf_pkg::ST_IDLE: begin
            if (accept) begin
               if (small_start) begin
                  cand_in  = npf_pkg::SMALL_PRIME;
                  state_in = npf_pkg::ST_FOUND;
               end else begin
                  cand_in  = req_start_value[npf_pkg::CAND_W-1:0];
                  state_in = npf_pkg::ST_CAND;
               end
            end
         end
         npf_pkg::ST_CAND: begin
            // the top 31-bit value ends the search untested
            if (cand_ff == npf_pkg::CAND_TOP) begin
               state_in = npf_pkg::ST_FOUND;
            end else begin
               d_in     = D_FIRST;
               sq_in    = SQ_FIRST;
               state_in = npf_pkg::ST_TEST;
            end
         end
         npf_pkg::ST_TEST: begin
            if ((d_ff > D_MAX) || (sq_cmp > cand_cmp)) begin
               state_in = npf_pkg::ST_FOUND;
            end else begin
               div_start = 1'b1;
               state_in  = npf_pkg::ST_DIV;
            end
         end
         npf_pkg::ST_DIV: begin
            if (div_done) begin
               if (div_rem == '0) begin
                  cand_in  = cand_ff + npf_pkg::CAND_W'(1);
                  state_in = npf_pkg::ST_CAND;
               end else begin
                  d_in     = d_ff + DW'(1);
                  sq_in    = sq_ff + sq_step;
                  state_in = npf_pkg::ST_TEST;
               end
            end
         end
         npf_pkg::ST_FOUND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = cand_ff;
               state_in     = npf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff      <= cand_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_prime = rsp_prime_ff;

`ifndef SYNTH
   // remainder only comes back while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == npf_pkg::ST_DIV))
      else $error("remainder returned outside divide wait");

   // divisor and candidate hold while the remainder unit runs
   a_div_operands_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == npf_pkg::ST_DIV) && $past(state_ff == npf_pkg::ST_DIV)
      |-> ($stable(d_ff) && $stable(cand_ff)))
      else $error("operands moved during divide");

   // no result below the smallest prime
   a_result_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_prime_ff >= npf_pkg::SMALL_PRIME))
      else $error("result below two");

   // a new result never overwrites one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(rsp_prime_ff) && rsp_valid_ff))
      else $error("pending result overwritten");
`endif

endmodule

// File: verif/tb_next_prime_finder.sv
// tb_next_prime_finder: self-checking testbench for the next prime finder
// depends on npf_pkg and next_prime_finder; a scoreboard class predicts each
// expected prime by trial division and checks results in order
module tb_next_prime_finder;

   localparam int unsigned TRIAL_LIMIT   = 46340;
   localparam int          RANDOM_ITEMS  = 80;
   localparam int          DRAIN_CYCLES  = 100;
   // a large prime is tried against every divisor up to its square root, so leave ample room
   localparam int          QUIET_LIMIT   = 8000000;

   class prime_scoreboard;
      logic [npf_pkg::CAND_W-1:0] expected_primes[$];
      int unsigned                checked;
      int unsigned                errors;

      function bit is_prime(longint unsigned c);
         if (c <= 1) return 1'b0;
         for (longint unsigned d = 2; d <= TRIAL_LIMIT; d++) begin
            if (d * d > c) break;
            if (c % d == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      function logic [npf_pkg::CAND_W-1:0] smallest_prime_from(
         logic signed [npf_pkg::IN_W-1:0] start);
         longint unsigned cand;
         if (start <= 2) return npf_pkg::SMALL_PRIME;
         cand = longint'(start[npf_pkg::CAND_W-1:0]);
         while (cand < longint'(npf_pkg::CAND_TOP) && !is_prime(cand)) cand++;
         return cand[npf_pkg::CAND_W-1:0];
      endfunction

      function void note_start(logic signed [npf_pkg::IN_W-1:0] start);
         expected_primes.push_back(smallest_prime_from(start));
      endfunction

      function void check_prime(logic [npf_pkg::CAND_W-1:0] got);
         logic [npf_pkg::CAND_W-1:0] want;
         if (expected_primes.size() == 0) begin
            errors++;
            if (errors <= 10) $display("result %0d arrived with nothing expected", got);
            return;
         end
         want = expected_primes.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("next_prime mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int pending();
         return expected_primes.size();
      endfunction
   endclass

   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_ready;
   logic signed [npf_pkg::IN_W-1:0]   req_start_value = '0;
   logic                              rsp_valid;
   logic                              rsp_ready       = 1'b0;
   logic [npf_pkg::CAND_W-1:0]        rsp_next_prime;

   prime_scoreboard sb;
   int unsigned     send_idle_pct = 14;
   int unsigned     recv_idle_pct = 50;
   int unsigned     quiet_cycles  = 0;
   int unsigned     n_directed    = 0;
   int unsigned     n_random      = 0;
   int unsigned     n_negative    = 0;
   bit              moved;

   // bit patterns, small-prime edges, prime squares and the top of range
   int directed_starts[$] = '{
      32'h8000_0000, -1, 0, 1, 2, 3, 4, 5, 8, 9, 24, 25, 90, 114, 121,
      1000, 65536, 32'hD555_5555, 2147483647
   };

   next_prime_finder #(
      .MAX_TRIAL_DIVISOR(TRIAL_LIMIT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_value(req_start_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_next_prime (rsp_next_prime)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_valid && req_ready) begin
            sb.note_start(req_start_value);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_prime(rsp_next_prime);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles", quiet_cycles);
            $display("[next_prime_finder] ERROR");
            $finish;
         end
      end
   end

   task automatic send_start(input logic signed [npf_pkg::IN_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_start_value <= value;
      if (value < 0) n_negative++;
      do @(posedge clock); while (!req_ready);
   endtask

   // mostly small starts keep the trial division short
   function automatic logic signed [npf_pkg::IN_W-1:0] random_start();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15) return {1'b1, 31'($urandom)};
      if (pick < 25) return $urandom_range(64);
      if (pick < 85) return $urandom_range(20000, 3);
      if (pick < 97) return $urandom_range(300000, 20000);
      return $urandom_range(4000000, 1000000);
   endfunction

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_starts[i]) begin
         send_start(directed_starts[i]);
         n_directed++;
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 14;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_start(random_start());
         n_random++;
      end
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d directed and %0d random start values, %0d of them negative",
               n_directed, n_random, n_negative);
      $display("%0d primes checked, %0d mismatches, %0d still expected",
               sb.checked, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[next_prime_finder] OK");
      end else begin
         $display("[next_prime_finder] ERROR");
      end
      $finish;
   end

endmodule
